// File: hdl/tour_mutation_engine_assert.svh
// ----------------------------------------------------------------------------
// Tour mutation engine assertion macros
// Clocked assertion wrappers used by the engine's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef TOUR_MUTATION_ENGINE_ASSERT_SVH
`define TOUR_MUTATION_ENGINE_ASSERT_SVH

// Check on every clock edge outside reset.
`define TME_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define TME_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hdl/tme_pkg.sv
// ----------------------------------------------------------------------------
// Tour mutation engine package
// Field widths, command codes and payload types shared by the engine files.
// ----------------------------------------------------------------------------
package tme_pkg;

  // Store depth and field widths
  localparam int MaxCities = 64;
  localparam int IdxW      = 6;
  localparam int CityW     = 6;
  localparam int CntW      = 7;
  localparam int CmdW      = 3;

  localparam logic [CntW-1:0] CountReset = CntW'(MaxCities);

  // Command codes
  localparam logic [CmdW-1:0] CmdLoad   = 3'd0;
  localparam logic [CmdW-1:0] CmdRead   = 3'd1;
  localparam logic [CmdW-1:0] CmdSwap   = 3'd2;
  localparam logic [CmdW-1:0] CmdRotate = 3'd3;
  localparam logic [CmdW-1:0] CmdBlock  = 3'd4;
  localparam logic [CmdW-1:0] CmdInvert = 3'd5;

  // Status codes
  localparam logic StatDone    = 1'b0;
  localparam logic StatIllegal = 1'b1;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [IdxW-1:0]  index_a;
    logic [CntW-1:0]  index_b;
    logic [CityW-1:0] city_value;
  } in_item_t;

  typedef struct packed {
    logic [CityW-1:0] read_value;
    logic             status;
  } out_item_t;

  // Tour store access for one cycle
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [CityW-1:0] wdata;
    logic [IdxW-1:0]  raddr;
  } ram_req_t;

endpackage

// File: hdl/tme_channels.sv
// ----------------------------------------------------------------------------
// Tour mutation engine channels
// Valid/ready interfaces for the command, result and configuration channels.
// ----------------------------------------------------------------------------
interface tme_in_if import tme_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tme_out_if import tme_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tme_cfg_if import tme_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CntW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/tme_tour_ram.sv
// ----------------------------------------------------------------------------
// Tour store RAM
// One write port and one read port, read data registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module tme_tour_ram import tme_pkg::*; (
  input  logic             clk_i,
  input  ram_req_t         req_i,
  output logic [CityW-1:0] rdata_o
);

  logic [CityW-1:0] mem [MaxCities];
  logic [CityW-1:0] rdata_q;

  // Write one entry and read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/tour_mutation_engine.sv
// ----------------------------------------------------------------------------
// Tour mutation engine
// Holds a tour in a RAM and applies load, read and four mutation commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch_i carries one command per transfer; res_ch_o returns exactly one
//   result per command (read_value, status), in order. cfg_ch_i writes the
//   city count and is always ready; write it only while the engine is idle.
//   The next command transfers in the cycle after the result enters the output
//   register, even while that result still waits there.
//   Path from the command transfer to the result:
//     load or illegal command: straight to the result, read: via StRead,
//     swap: one pair, block swap of k pairs: k pairs,
//     inversion of a block of length L: floor(L/2) pairs,
//     rotate: three inversions back to back.
//   Every mutation runs as pairs of exchanged entries through the single
//   RAM read port and single write port, each pair through the StLoA and
//   StHiB states in turn.
//   Reset sets the city count to 64 and empties the output register; tour
//   entries are undefined until loaded. When the receiver stalls, the
//   finished result holds in the output register and the engine waits
//   with its next result until the register frees up.
// ----------------------------------------------------------------------------
`include "tour_mutation_engine_assert.svh"

module tour_mutation_engine import tme_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tme_cfg_if.sink   cfg_ch_i,
  tme_in_if.sink    in_ch_i,
  tme_out_if.source res_ch_o
);

  // Sequencer states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StLoA  = 3'd2;
  localparam logic [2:0] StHiB  = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q;
  logic [CntW-1:0]  lo_q, lo_d, hi_q, hi_d, lim_q, lim_d;
  logic             inv_q, inv_d;
  logic [1:0]       pass_q, pass_d;
  logic [IdxW-1:0]  rot_q, rot_d;
  logic             act_q, act_d;
  logic             pend_q, pend_d;
  logic [IdxW-1:0]  plo_q, plo_d, phi_q, phi_d;
  logic [CityW-1:0] hold_q, hold_d;
  logic [CityW-1:0] res_val_q, res_val_d;
  logic             res_st_q, res_st_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_data_q, out_data_d;

  ram_req_t         ram_req;
  logic [CityW-1:0] ram_rdata;

  logic             in_xfer;
  logic [CntW-1:0]  a_ext, m_half, n_last;
  logic             cnt_ok, a_pos, more;
  in_item_t         cmd_in;
  logic             load_xfer, pair_st;

  tme_tour_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Configuration register
  assign cfg_ch_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CountReset;
    end else if (cfg_ch_i.valid) begin
      cnt_q <= cfg_ch_i.data;
    end
  end

  // Command decode helpers
  assign cmd_in  = in_ch_i.data;
  assign in_ch_i.ready = (state_q == StIdle);
  assign in_xfer = in_ch_i.valid && in_ch_i.ready;
  assign a_ext   = {1'b0, cmd_in.index_a};
  assign m_half  = cnt_q >> 1;
  assign n_last  = cnt_q - CntW'(1);
  assign cnt_ok  = (cnt_q >= CntW'(3)) && (cnt_q <= CntW'(MaxCities));
  assign a_pos   = (cmd_in.index_a != '0);

  // Another pair left in the current pass
  assign more = inv_q ? (lo_q < hi_q) : (lo_q < lim_q);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    lim_d     = lim_q;
    inv_d     = inv_q;
    pass_d    = pass_q;
    rot_d     = rot_q;
    act_d     = act_q;
    pend_d    = pend_q;
    plo_d     = plo_q;
    phi_d     = phi_q;
    hold_d    = hold_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;

    ram_req.we    = 1'b0;
    ram_req.waddr = plo_q;
    ram_req.wdata = ram_rdata;
    ram_req.raddr = lo_q[IdxW-1:0];

    unique case (state_q)
      StIdle: begin
        ram_req.raddr = cmd_in.index_a;
        if (in_xfer) begin
          res_val_d = '0;
          res_st_d  = StatIllegal;
          pend_d    = 1'b0;
          state_d   = StFin;
          unique case (cmd_in.command)
            CmdLoad: begin
              if (a_ext < CntW'(MaxCities)) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cmd_in.index_a;
                ram_req.wdata = cmd_in.city_value;
                res_st_d      = StatDone;
              end
            end
            CmdRead: begin
              if (a_ext < CntW'(MaxCities)) begin
                res_st_d = StatDone;
                state_d  = StRead;
              end
            end
            CmdSwap: begin
              if (cnt_ok && a_pos && (cmd_in.index_b != '0) && (a_ext < cnt_q) &&
                  (cmd_in.index_b < cnt_q) && (a_ext != cmd_in.index_b)) begin
                lo_d     = a_ext;
                hi_d     = cmd_in.index_b;
                lim_d    = a_ext + CntW'(1);
                inv_d    = 1'b0;
                pass_d   = '0;
                res_st_d = StatDone;
                state_d  = StLoA;
              end
            end
            CmdRotate: begin
              // Rotate as three reversals: [1,a), [a,n), then [1,n)
              if (cnt_ok && a_pos && (a_ext < cnt_q)) begin
                lo_d     = CntW'(1);
                hi_d     = a_ext - CntW'(1);
                inv_d    = 1'b1;
                pass_d   = 2'd2;
                rot_d    = cmd_in.index_a;
                res_st_d = StatDone;
                state_d  = StLoA;
              end
            end
            CmdBlock: begin
              if (cnt_ok && a_pos && (a_ext <= cmd_in.index_b) &&
                  (cmd_in.index_b <= m_half)) begin
                lo_d     = a_ext;
                hi_d     = a_ext + m_half;
                lim_d    = cmd_in.index_b;
                inv_d    = 1'b0;
                pass_d   = '0;
                res_st_d = StatDone;
                state_d  = StLoA;
              end
            end
            CmdInvert: begin
              if (cnt_ok && a_pos && (a_ext <= cmd_in.index_b) &&
                  (cmd_in.index_b <= cnt_q)) begin
                lo_d     = a_ext;
                hi_d     = cmd_in.index_b - CntW'(1);
                inv_d    = 1'b1;
                pass_d   = '0;
                res_st_d = StatDone;
                state_d  = StLoA;
              end
            end
            default: begin
              res_st_d = StatIllegal;
            end
          endcase
        end
      end

      StRead: begin
        res_val_d = ram_rdata;
        state_d   = StFin;
      end

      // Write back the low entry of the previous pair, read the new low entry
      StLoA: begin
        ram_req.we    = pend_q;
        ram_req.waddr = plo_q;
        ram_req.wdata = ram_rdata;
        ram_req.raddr = lo_q[IdxW-1:0];
        act_d         = more;
        state_d       = StHiB;
      end

      // Write back the high entry of the previous pair, read the new high entry
      StHiB: begin
        ram_req.we    = pend_q;
        ram_req.waddr = phi_q;
        ram_req.wdata = hold_q;
        ram_req.raddr = hi_q[IdxW-1:0];
        hold_d        = ram_rdata;
        if (act_q) begin
          pend_d  = 1'b1;
          plo_d   = lo_q[IdxW-1:0];
          phi_d   = hi_q[IdxW-1:0];
          lo_d    = lo_q + CntW'(1);
          hi_d    = inv_q ? (hi_q - CntW'(1)) : (hi_q + CntW'(1));
          state_d = StLoA;
        end else begin
          pend_d = 1'b0;
          // Pass drained: start the next rotation pass or finish
          if (pass_q == 2'd2) begin
            lo_d    = {1'b0, rot_q};
            hi_d    = n_last;
            pass_d  = 2'd1;
            state_d = StLoA;
          end else if (pass_q == 2'd1) begin
            lo_d    = CntW'(1);
            hi_d    = n_last;
            pass_d  = 2'd0;
            state_d = StLoA;
          end else begin
            state_d = StFin;
          end
        end
      end

      StFin: begin
        if (!out_valid_q || res_ch_o.ready) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_ch_o.ready) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == StFin) && (!out_valid_q || res_ch_o.ready)) begin
      out_valid_d           = 1'b1;
      out_data_d.read_value = res_val_q;
      out_data_d.status     = res_st_q;
    end
  end

  assign res_ch_o.valid = out_valid_q;
  assign res_ch_o.data  = out_data_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pend_q      <= 1'b0;
      act_q       <= 1'b0;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      act_q       <= act_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    lim_q      <= lim_d;
    inv_q      <= inv_d;
    rot_q      <= rot_d;
    plo_q      <= plo_d;
    phi_q      <= phi_d;
    hold_q     <= hold_d;
    res_val_q  <= res_val_d;
    res_st_q   <= res_st_d;
    out_data_q <= out_data_d;
  end

  // Assertions
  assign load_xfer = in_xfer && (cmd_in.command == CmdLoad);
  assign pair_st   = (state_q == StLoA) || (state_q == StHiB);

  `TME_ASSERT(a_pair_distinct, pend_q |-> (plo_q != phi_q), "pending pair addresses coincide")
  `TME_ASSERT(a_write_source, ram_req.we |-> (pair_st || load_xfer), "stray tour write")
  `TME_ASSERT(a_result_from_fin, $rose(out_valid_q) |-> ($past(state_q) == StFin), "stray result")
  `TME_ASSERT(a_idle_drained, (state_q == StIdle) |-> !pend_q, "idle with write-back pending")
  `TME_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_q, "output not empty after reset")

endmodule
